FILE: hdl/x86mov_pkg.sv
`default_nettype none

package x86mov_pkg;

    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_RM  = 3'd1,
        FORM_IMM_REG = 3'd2,
        FORM_MEM_ACC = 3'd3,
        FORM_ACC_MEM = 3'd4,
        FORM_UNSUP   = 3'd5
    } form_t;

    localparam logic [7:0] RM_REG_MASK  = 8'hFC;
    localparam logic [7:0] RM_REG_CODE  = 8'h88;
    localparam logic [7:0] IMM_RM_MASK  = 8'hFE;
    localparam logic [7:0] IMM_RM_CODE  = 8'hC6;
    localparam logic [7:0] IMM_REG_MASK = 8'hF0;
    localparam logic [7:0] IMM_REG_CODE = 8'hB0;
    localparam logic [7:0] ACC_MASK     = 8'hFC;
    localparam logic [7:0] ACC_CODE     = 8'hA0;

    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_DIRECT  = 3'd6;

    localparam logic [2:0] UNSUP_LENGTH = 3'd1;
    localparam logic [2:0] OPCODE_ONLY  = 3'd1;
    localparam logic [2:0] MODRM_LENGTH = 3'd2;
    localparam logic [2:0] ACC_LENGTH   = 3'd3;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  length;
        logic        unsup;
    } snap_t;

    typedef struct packed {
        form_t       form;
        logic        wide;
        logic        reg_is_dest;
        logic [2:0]  reg_index;
        logic [1:0]  mode_bits;
        logic [2:0]  rm_index;
        logic        has_direct_address;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
    } rec_t;

    function automatic logic is_rm_reg(input logic [7:0] op);
        return (op & RM_REG_MASK) == RM_REG_CODE;
    endfunction

    function automatic logic is_imm_rm(input logic [7:0] op);
        return (op & IMM_RM_MASK) == IMM_RM_CODE;
    endfunction

    function automatic logic is_imm_reg(input logic [7:0] op);
        return (op & IMM_REG_MASK) == IMM_REG_CODE;
    endfunction

    function automatic logic is_acc(input logic [7:0] op);
        return (op & ACC_MASK) == ACC_CODE;
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            MOD_DISP8:  n = 2'd1;
            MOD_DISP16: n = 2'd2;
            MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] widen(input logic [15:0] hold, input logic [1:0] n);
        logic [15:0] v;
        case (n)
            2'd1:    v = {{8{hold[7]}}, hold[7:0]};
            2'd2:    v = hold;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] put_byte(input logic [15:0] hold, input logic [2:0] k,
                                             input logic [7:0] b);
        logic [15:0] v;
        case (k)
            3'd0:    v = {hold[15:8], b};
            3'd1:    v = {b, hold[7:0]};
            default: v = hold;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/x86mov_collect.sv
`default_nettype none

module x86mov_collect (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        code_byte,
    output x86mov_pkg::snap_t      snap,
    output logic                   fire
);
    import x86mov_pkg::*;

    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [2:0]  seen_reg, seen_next;
    logic [2:0]  needed_reg, needed_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [2:0]  seen_adv;
    logic        unsup;
    logic [1:0]  dn;
    logic [1:0]  imm_n;
    logic [2:0]  k;

    always_comb
    begin
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        seen_next   = seen_reg;
        needed_next = needed_reg;
        disp_next   = disp_reg;
        imm_next    = imm_reg;
        seen_adv    = seen_reg + 3'd1;
        unsup       = 1'b0;
        fire        = 1'b0;
        dn          = disp_bytes(modrm_reg);
        imm_n       = 2'd0;
        k           = seen_reg - 3'd2;
        if (seen_reg == 3'd0)
        begin
            opcode_next = code_byte;
            modrm_next  = 8'd0;
            disp_next   = 16'd0;
            imm_next    = 16'd0;
            seen_next   = OPCODE_ONLY;
            if (is_rm_reg(code_byte) || is_imm_rm(code_byte))
            begin
                needed_next = MODRM_LENGTH;
            end
            else if (is_imm_reg(code_byte))
            begin
                needed_next = MODRM_LENGTH + {2'd0, code_byte[3]};
            end
            else if (is_acc(code_byte))
            begin
                needed_next = ACC_LENGTH;
            end
            else
            begin
                needed_next = 3'd0;
                seen_next   = 3'd0;
                unsup       = 1'b1;
                fire        = 1'b1;
            end
        end
        else
        begin
            if (is_rm_reg(opcode_reg) || is_imm_rm(opcode_reg))
            begin
                if (seen_reg == OPCODE_ONLY)
                begin
                    imm_n       = is_imm_rm(opcode_reg) ? {1'b0, 1'b1} + {1'b0, opcode_reg[0]}
                                                        : 2'd0;
                    modrm_next  = code_byte;
                    needed_next = MODRM_LENGTH + {1'b0, disp_bytes(code_byte)} + {1'b0, imm_n};
                end
                else if (k < {1'b0, dn})
                begin
                    disp_next = put_byte(disp_reg, k, code_byte);
                end
                else
                begin
                    imm_next = put_byte(imm_reg, k - {1'b0, dn}, code_byte);
                end
            end
            else if (is_imm_reg(opcode_reg))
            begin
                imm_next = put_byte(imm_reg, seen_reg - 3'd1, code_byte);
            end
            else
            begin
                disp_next = put_byte(disp_reg, seen_reg - 3'd1, code_byte);
            end
            seen_next = seen_adv;
            if (seen_adv >= needed_next)
            begin
                fire        = 1'b1;
                seen_next   = 3'd0;
                needed_next = 3'd0;
            end
        end
    end

    always_comb
    begin
        snap.opcode = opcode_next;
        snap.modrm  = modrm_next;
        snap.disp   = disp_next;
        snap.imm    = imm_next;
        snap.length = unsup ? UNSUP_LENGTH : seen_adv;
        snap.unsup  = unsup;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= 8'd0;
            modrm_reg  <= 8'd0;
            seen_reg   <= 3'd0;
            needed_reg <= 3'd0;
            disp_reg   <= 16'd0;
            imm_reg    <= 16'd0;
        end
        else if (accept)
        begin
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            seen_reg   <= seen_next;
            needed_reg <= needed_next;
            disp_reg   <= disp_next;
            imm_reg    <= imm_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/x86mov_format.sv
`default_nettype none

module x86mov_format (
    input  x86mov_pkg::snap_t snap,
    output x86mov_pkg::rec_t  rec
);
    import x86mov_pkg::*;

    logic [1:0] dn;

    always_comb
    begin
        rec        = '0;
        rec.form   = FORM_UNSUP;
        rec.length = snap.length;
        dn         = disp_bytes(snap.modrm);
        if (snap.unsup)
        begin
            rec.form = FORM_UNSUP;
        end
        else if (is_rm_reg(snap.opcode) || is_imm_rm(snap.opcode))
        begin
            rec.form               = is_rm_reg(snap.opcode) ? FORM_RM_REG : FORM_IMM_RM;
            rec.wide               = snap.opcode[0];
            rec.reg_is_dest        = is_rm_reg(snap.opcode) ? snap.opcode[1] : 1'b0;
            rec.reg_index          = snap.modrm[5:3];
            rec.mode_bits          = snap.modrm[7:6];
            rec.rm_index           = snap.modrm[2:0];
            rec.has_direct_address = (snap.modrm[7:6] == MOD_MEM) &&
                                     (snap.modrm[2:0] == RM_DIRECT);
            rec.displacement       = widen(snap.disp, dn);
            rec.immediate          = is_imm_rm(snap.opcode)
                                   ? widen(snap.imm, {1'b0, 1'b1} + {1'b0, snap.opcode[0]})
                                   : 16'd0;
        end
        else if (is_imm_reg(snap.opcode))
        begin
            rec.form        = FORM_IMM_REG;
            rec.wide        = snap.opcode[3];
            rec.reg_is_dest = 1'b1;
            rec.reg_index   = snap.opcode[2:0];
            rec.immediate   = widen(snap.imm, {1'b0, 1'b1} + {1'b0, snap.opcode[3]});
        end
        else
        begin
            rec.form               = snap.opcode[1] ? FORM_ACC_MEM : FORM_MEM_ACC;
            rec.wide               = snap.opcode[0];
            rec.reg_is_dest        = ~snap.opcode[1];
            rec.has_direct_address = 1'b1;
            rec.displacement       = snap.disp;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/x86_16_mov_instruction_decoder.sv
// Channel | Signals                                   | Request
// --------+-------------------------------------------+--------------------------
// code    | code_valid, code_ready, code_byte         | one byte of code stream
// rec     | rec_valid, rec_ready, form .. length      | one decoded MOV record
//
// One byte is taken per cycle while code_ready is high; each record is registered.
// The byte collector register and the result register bound the single pass.
// A two-entry result buffer keeps bytes flowing while one record waits.
// code_ready drops only when both result entries are full.
// Reset clears the collector and empties the result buffer.
`default_nettype none

module x86_16_mov_instruction_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               code_valid,
    output logic                    code_ready,
    input  wire logic [7:0]         code_byte,
    output logic                    rec_valid,
    input  wire logic               rec_ready,
    output x86mov_pkg::form_t       form,
    output logic                    wide,
    output logic                    reg_is_dest,
    output logic [2:0]              reg_index,
    output logic [1:0]              mode_bits,
    output logic [2:0]              rm_index,
    output logic                    has_direct_address,
    output logic signed [15:0]      displacement,
    output logic signed [15:0]      immediate,
    output logic [2:0]              length
);
    import x86mov_pkg::*;

    snap_t snap;
    rec_t  rec;
    logic  fire;
    logic  accept;
    logic  take;
    logic  push;

    logic  out_valid_reg, out_valid_next;
    rec_t  out_rec_reg, out_rec_next;
    logic  skid_valid_reg, skid_valid_next;
    rec_t  skid_rec_reg, skid_rec_next;

    assign code_ready = ~skid_valid_reg;
    assign accept     = code_valid & code_ready;
    assign push       = accept & fire;
    assign take       = out_valid_reg & rec_ready;

    x86mov_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_byte (code_byte),
        .snap      (snap),
        .fire      (fire)
    );

    x86mov_format u_format (
        .snap (snap),
        .rec  (rec)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_valid_next = skid_valid_reg;
        skid_rec_next   = skid_rec_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = skid_rec_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_rec_next   = rec;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_rec_next   = rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign rec_valid          = out_valid_reg;
    assign form               = out_rec_reg.form;
    assign wide               = out_rec_reg.wide;
    assign reg_is_dest        = out_rec_reg.reg_is_dest;
    assign reg_index          = out_rec_reg.reg_index;
    assign mode_bits          = out_rec_reg.mode_bits;
    assign rm_index           = out_rec_reg.rm_index;
    assign has_direct_address = out_rec_reg.has_direct_address;
    assign displacement       = $signed(out_rec_reg.displacement);
    assign immediate          = $signed(out_rec_reg.immediate);
    assign length             = out_rec_reg.length;

endmodule

`default_nettype wire

FILE: hdl/x86mov_checker.sv
`default_nettype none

module x86mov_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               code_valid,
    input  wire logic               code_ready,
    input  wire logic [7:0]         code_byte,
    input  wire logic               rec_valid,
    input  wire logic               rec_ready,
    input  x86mov_pkg::form_t       form,
    input  wire logic               wide,
    input  wire logic               reg_is_dest,
    input  wire logic [2:0]         reg_index,
    input  wire logic [1:0]         mode_bits,
    input  wire logic [2:0]         rm_index,
    input  wire logic               has_direct_address,
    input  wire logic signed [15:0] displacement,
    input  wire logic signed [15:0] immediate,
    input  wire logic [2:0]         length
);
    import x86mov_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(form) && $stable(length)
            && $stable(displacement) && $stable(immediate))
        else $error("record changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && form == FORM_UNSUP |-> length == UNSUP_LENGTH && !wide
            && displacement == 16'sd0 && immediate == 16'sd0)
        else $error("unsupported record not clean");

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (form == FORM_MEM_ACC || form == FORM_ACC_MEM) |->
            has_direct_address && length == ACC_LENGTH && reg_index == 3'd0
            && immediate == 16'sd0)
        else $error("accumulator record malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && form == FORM_IMM_REG |-> reg_is_dest && mode_bits == MOD_MEM
            && rm_index == 3'd0 && length == MODRM_LENGTH + {2'd0, wide})
        else $error("immediate-to-register record malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && form == FORM_RM_REG && mode_bits == MOD_REG |->
            length == MODRM_LENGTH && displacement == 16'sd0 && !has_direct_address)
        else $error("register-to-register record malformed");

endmodule

bind x86_16_mov_instruction_decoder x86mov_checker u_x86mov_checker (.*);

`default_nettype wire
